// ----- design/mwm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared types and constants of the smoothed mecanum wheel mixer.
// ----------------------------------------------------------------------------
package mwm_pkg;

    localparam int VEL_W    = 16;
    localparam int CFG_W    = 15;
    localparam int CFG_IDX_W = 2;
    localparam int DIR_W    = 2;
    localparam int DUTY_W   = 15;
    localparam int NUM_WHEELS = 4;

    // target and average span: three q1.15 terms
    localparam int TGT_W    = 18;
    localparam int AVG_W    = 18;
    // target minus average
    localparam int DIFF_W   = 19;
    // difference after the positive offset
    localparam int UOFS_W   = 20;

    localparam int AVG_LEN_DEF = 19;

    localparam logic [CFG_W-1:0] SPEED_LIMIT_RST = 15'd32767;
    localparam logic [CFG_W-1:0] YAW_GAIN_RST    = 15'd19228;
    localparam logic [DUTY_W-1:0] DUTY_MAX       = 15'd32767;

    typedef enum logic [DIR_W-1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_LIMIT = 2'd0,
        CFG_YAW_GAIN    = 2'd1
    } t_cfg_idx;

endpackage
`default_nettype wire

// ----- design/mecanum_wheel_mixer_smoothed.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_smoothed
// Clamps a velocity command, mixes it into four mecanum wheel targets,
// smooths each wheel with a moving average and reports direction and duty.
// ----------------------------------------------------------------------------
// channel   signals                                   role
// in        i_valid o_ready i_vx i_vy i_wz            velocity command item
// out       o_valid i_ready o_<wheel>_dir/_duty       wheel drive item
// cfg       i_cfg_valid o_cfg_ready i_cfg_index/data  register write
//
// one item per cycle while the output is not stalled; the result passes the input, target and output registers
// stage one: input register; stage two: clamp, yaw multiply, mixing;
// stage three: average update through one reciprocal multiply per wheel
// the wheel averages close their loop within stage three
// reset clears the averages and loads the register defaults
// a stalled output holds the pipeline back stage by stage
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_smoothed #(
    parameter int AVG_LEN = mwm_pkg::AVG_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [mwm_pkg::VEL_W-1:0] i_vx,
    input  wire logic signed [mwm_pkg::VEL_W-1:0] i_vy,
    input  wire logic signed [mwm_pkg::VEL_W-1:0] i_wz,

    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [mwm_pkg::DIR_W-1:0]          o_front_left_dir,
    output logic [mwm_pkg::DUTY_W-1:0]         o_front_left_duty,
    output logic [mwm_pkg::DIR_W-1:0]          o_front_right_dir,
    output logic [mwm_pkg::DUTY_W-1:0]         o_front_right_duty,
    output logic [mwm_pkg::DIR_W-1:0]          o_rear_left_dir,
    output logic [mwm_pkg::DUTY_W-1:0]         o_rear_left_duty,
    output logic [mwm_pkg::DIR_W-1:0]          o_rear_right_dir,
    output logic [mwm_pkg::DUTY_W-1:0]         o_rear_right_duty,

    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mwm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mwm_pkg::CFG_W-1:0]     i_cfg_data
);
    import mwm_pkg::*;

    localparam int SUM_W   = UOFS_W + 2;
    localparam int OfsKInt = (2 ** (DIFF_W - 1) + AVG_LEN - 1) / AVG_LEN;
    localparam int OfsKnInt = OfsKInt * AVG_LEN;
    localparam int REC_S   = UOFS_W + $clog2(AVG_LEN);
    localparam int RecMInt = (2 ** REC_S + AVG_LEN - 1) / AVG_LEN;
    localparam int PROD_W  = UOFS_W + REC_S + 1;
    localparam int QU_W    = PROD_W - REC_S;

    localparam logic [UOFS_W-1:0] OFS_KN = OfsKnInt[UOFS_W-1:0];
    localparam logic [SUM_W-1:0]  OFS_K  = OfsKInt[SUM_W-1:0];
    localparam logic [REC_S:0]    REC_M  = RecMInt[REC_S:0];

    // configuration
    logic [CFG_W-1:0] r_speed_limit;
    logic [CFG_W-1:0] r_yaw_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit <= SPEED_LIMIT_RST;
            r_yaw_gain    <= YAW_GAIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data;
                CFG_YAW_GAIN:    r_yaw_gain    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic s3_ready;
    logic s2_adv;
    logic s2_ready;
    logic s1_adv;

    assign s3_ready = !r_out_valid || i_ready;
    assign s2_adv   = r_s2_valid && s3_ready;
    assign s2_ready = !r_s2_valid || s2_adv;
    assign s1_adv   = r_s1_valid && s2_ready;
    assign o_ready  = !r_s1_valid || s2_ready;
    assign o_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // stage one: input register
    logic signed [VEL_W-1:0] r_vx;
    logic signed [VEL_W-1:0] r_vy;
    logic signed [VEL_W-1:0] r_wz;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_vx <= i_vx;
            r_vy <= i_vy;
            r_wz <= i_wz;
        end
    end

    // stage two: clamp, yaw term, mixing
    logic signed [VEL_W:0]     lim_pos;
    logic signed [VEL_W:0]     lim_neg;
    logic signed [VEL_W:0]     vx_ext;
    logic signed [VEL_W:0]     vy_ext;
    logic signed [VEL_W:0]     vx_clamp;
    logic signed [VEL_W:0]     vy_clamp;
    logic signed [2*VEL_W-1:0] yaw_prod;
    logic signed [2*VEL_W-1:0] yaw_adj;
    logic signed [VEL_W-1:0]   yaw;
    logic signed [TGT_W-1:0]   vx_t;
    logic signed [TGT_W-1:0]   vy_t;
    logic signed [TGT_W-1:0]   yaw_t;
    logic signed [TGT_W-1:0]   n_tgt [NUM_WHEELS];
    logic signed [TGT_W-1:0]   r_tgt [NUM_WHEELS];

    always_comb begin
        lim_pos = $signed({2'b00, r_speed_limit});
        lim_neg = -lim_pos;
        vx_ext  = {r_vx[VEL_W-1], r_vx};
        vy_ext  = {r_vy[VEL_W-1], r_vy};
        if (vx_ext > lim_pos) begin
            vx_clamp = lim_pos;
        end else if (vx_ext < lim_neg) begin
            vx_clamp = lim_neg;
        end else begin
            vx_clamp = vx_ext;
        end
        if (vy_ext > lim_pos) begin
            vy_clamp = lim_pos;
        end else if (vy_ext < lim_neg) begin
            vy_clamp = lim_neg;
        end else begin
            vy_clamp = vy_ext;
        end
        // truncate toward zero
        yaw_prod = r_wz * $signed({1'b0, r_yaw_gain});
        yaw_adj  = yaw_prod + (yaw_prod[2*VEL_W-1] ? 32'sd32767 : 32'sd0);
        yaw      = yaw_adj[2*VEL_W-2:CFG_W];
        vx_t     = TGT_W'(vx_clamp);
        vy_t     = TGT_W'(vy_clamp);
        yaw_t    = TGT_W'(yaw);
        n_tgt[0] = vx_t - vy_t - yaw_t;
        n_tgt[1] = vx_t + vy_t + yaw_t;
        n_tgt[2] = vx_t + vy_t - yaw_t;
        n_tgt[3] = vx_t - vy_t + yaw_t;
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_tgt <= n_tgt;
        end
    end

    // stage three: average update, direction and duty
    logic signed [AVG_W-1:0] r_avg  [NUM_WHEELS];
    logic signed [AVG_W-1:0] n_avg  [NUM_WHEELS];
    t_dir                    n_dir  [NUM_WHEELS];
    logic [DUTY_W-1:0]       n_duty [NUM_WHEELS];
    t_dir                    r_dir  [NUM_WHEELS];
    logic [DUTY_W-1:0]       r_duty [NUM_WHEELS];

    for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_wheel
        logic signed [DIFF_W-1:0] diff;
        logic [UOFS_W-1:0]        uofs;
        logic [PROD_W-1:0]        rprod;
        logic [QU_W-1:0]          quo;
        logic                     rem_nz;
        logic signed [SUM_W-1:0]  fdiv;
        logic signed [SUM_W-1:0]  acc;
        logic signed [AVG_W-1:0]  avg_new;
        logic [AVG_W-1:0]         mag;

        // floor of diff / len through an offset and a reciprocal multiply
        always_comb begin
            diff   = DIFF_W'(r_tgt[w]) - DIFF_W'(r_avg[w]);
            uofs   = UOFS_W'(diff) + OFS_KN;
            rprod  = PROD_W'(uofs) * PROD_W'(REC_M);
            quo    = rprod[PROD_W-1:REC_S];
            rem_nz = {1'b0, rprod[REC_S-1:0]} >= REC_M;
            fdiv   = $signed(SUM_W'(quo)) - $signed(OFS_K);
            acc    = SUM_W'(r_avg[w]) + fdiv;
            // negative sum rounds toward zero
            if (acc < 0 && rem_nz) begin
                acc = acc + SUM_W'(1);
            end
            avg_new  = acc[AVG_W-1:0];
            n_avg[w] = avg_new;
            mag      = avg_new[AVG_W-1] ? AVG_W'(-avg_new) : AVG_W'(avg_new);
            if (avg_new == '0) begin
                n_dir[w] = DIR_STOP;
            end else if (avg_new[AVG_W-1]) begin
                n_dir[w] = DIR_REV;
            end else begin
                n_dir[w] = DIR_FWD;
            end
            n_duty[w] = (mag > AVG_W'(DUTY_MAX)) ? DUTY_MAX : mag[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r_avg[k] <= '0;
            end
        end else if (s2_adv) begin
            r_avg <= n_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_dir  <= n_dir;
            r_duty <= n_duty;
        end
    end

    assign o_front_left_dir   = r_dir[0];
    assign o_front_left_duty  = r_duty[0];
    assign o_front_right_dir  = r_dir[1];
    assign o_front_right_duty = r_duty[1];
    assign o_rear_left_dir    = r_dir[2];
    assign o_rear_left_duty   = r_duty[2];
    assign o_rear_right_dir   = r_dir[3];
    assign o_rear_right_duty  = r_duty[3];

    // checks
    a_avg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s2_adv |=> (r_avg[0] == $past(r_avg[0])) && (r_avg[3] == $past(r_avg[3])))
        else $error("wheel average moved without an item");

    a_avg_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_avg[0] == '0) && (r_avg[1] == '0) && (r_avg[2] == '0)
            && (r_avg[3] == '0))
        else $error("wheel average not cleared by reset");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s3_ready) |=> r_s2_valid && $stable(r_tgt[0]) && $stable(r_tgt[1]))
        else $error("stalled target item lost");

    a_dir_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_front_left_dir == DIR_STOP) == (o_front_left_duty == '0))
            && ((o_rear_right_dir == DIR_STOP) == (o_rear_right_duty == '0)))
        else $error("direction and duty disagree");

endmodule
`default_nettype wire
